FILE: hdl/msort_pkg.sv
// Shared types and constants for the merge sorter.
// No dependencies; used by msort_step and merge_sorter_top.
`timescale 1ns / 1ps

package msort_pkg;

   // element width and widest count the design supports
   localparam int DATA_W    = 32;
   localparam int MAX_DEPTH = 64;
   localparam int CNT_W     = $clog2(MAX_DEPTH + 1);

   // merge cursor: heads of both runs, output slot, run bounds
   typedef struct packed {
      logic [CNT_W-1:0] i;
      logic [CNT_W-1:0] j;
      logic [CNT_W-1:0] k;
      logic [CNT_W-1:0] mid;
      logic [CNT_W-1:0] hi;
   } ptr_type;

   // status of one merge step
   typedef struct packed {
      logic take_j;
      logic blk_done;
   } step_type;

endpackage

FILE: hdl/merge_sorter_top.sv
// Merge sorter top level: run buffer, scratch buffer and merge sequencer.
// Depends on msort_pkg and msort_step.
`timescale 1ns / 1ps

// Collects a run of signed 32-bit values, one per input beat, up to DEPTH
// of them; beats beyond that are dropped and rsp_tuser is set on every
// result of the run. After the beat with tlast the run is sorted ascending
// by a bottom-up merge that ping-pongs between two buffers, then emitted,
// with rsp_tlast on the greatest value. The input is not ready while a run
// is sorted or emitted. One shared compare unit produces one merged element
// per cycle; each pass opens with a setup state (ST_TURN), and after the
// last pass a read state (ST_FETCH) precedes the results, which then leave
// at one result beat per cycle while the sink is ready.

module merge_sorter_top #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   // input beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,
   // result beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] sorted_value
   output logic        rsp_tlast,
   output logic        rsp_tuser    // [0] overflowed
);

   localparam int CNT_W = msort_pkg::CNT_W;
   localparam int DW    = msort_pkg::DATA_W;
   localparam int AW    = $clog2(DEPTH);
   localparam int MEM_N = 2 ** AW;

   localparam logic [CNT_W-1:0] CAP = CNT_W'(DEPTH);

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_TURN  = 3'd1;
   localparam logic [2:0] ST_MERGE = 3'd2;
   localparam logic [2:0] ST_FETCH = 3'd3;
   localparam logic [2:0] ST_SHOW  = 3'd4;

   // smaller of a grown sum and the run length
   function automatic logic [CNT_W-1:0] clamp(input logic [CNT_W:0] a,
                                               input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] r;
      r = (a > {1'b0, n}) ? n : a[CNT_W-1:0];
      return r;
   endfunction

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                ovf_ff, ovf_in;
   logic [CNT_W-1:0]    w_ff, w_in;
   logic                src_ff, src_in;
   msort_pkg::ptr_type  ptr_ff, ptr_in;

   logic [DW-1:0] elm_mem_ff [MEM_N];
   logic [DW-1:0] scr_mem_ff [MEM_N];
   logic [DW-1:0] elm_a_ff, elm_b_ff, scr_a_ff, scr_b_ff;

   logic [DW-1:0]       head_a, head_b;
   msort_pkg::ptr_type  step_ptr;
   msort_pkg::step_type step_stat;
   logic [DW-1:0]       step_data;

   logic          req_beat, rsp_beat, at_final;
   logic          elm_we, scr_we;
   logic [AW-1:0] wr_addr;
   logic [DW-1:0] wr_data;
   logic [CNT_W:0] w_dbl;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;
   assign at_final = ptr_ff.i == (cnt_ff - 1'b1);
   assign w_dbl    = {w_ff, 1'b0};

   // heads of the source buffer of the current pass
   assign head_a = src_ff ? scr_a_ff : elm_a_ff;
   assign head_b = src_ff ? scr_b_ff : elm_b_ff;

   msort_step u_step (
      .ptr_cur (ptr_ff),
      .head_a  (head_a),
      .head_b  (head_b),
      .ptr_nxt (step_ptr),
      .stat    (step_stat),
      .wr_data (step_data)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      w_in     = w_ff;
      src_in   = src_ff;
      ptr_in   = ptr_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_beat) begin
               if (cnt_ff < CAP) begin
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  w_in     = CNT_W'(1);
                  src_in   = 1'b0;
                  ptr_in.i = '0;
                  state_in = (cnt_in > CNT_W'(1)) ? ST_TURN : ST_FETCH;
               end
            end
         end
         ST_TURN: begin
            // first pair of runs of a pass
            ptr_in.i   = '0;
            ptr_in.k   = '0;
            ptr_in.mid = clamp({1'b0, w_ff}, cnt_ff);
            ptr_in.j   = ptr_in.mid;
            ptr_in.hi  = clamp(w_dbl, cnt_ff);
            state_in   = ST_MERGE;
         end
         ST_MERGE: begin
            ptr_in = step_ptr;
            if (step_stat.blk_done) begin
               if (ptr_ff.hi == cnt_ff) begin
                  // pass done: widen runs, swap buffers
                  w_in   = w_dbl[CNT_W-1:0];
                  src_in = !src_ff;
                  if (w_dbl >= {1'b0, cnt_ff}) begin
                     ptr_in.i = '0;
                     state_in = ST_FETCH;
                  end else begin
                     state_in = ST_TURN;
                  end
               end else begin
                  // next pair of runs in this pass
                  ptr_in.i   = ptr_ff.hi;
                  ptr_in.k   = ptr_ff.hi;
                  ptr_in.mid = clamp({1'b0, ptr_ff.hi} + {1'b0, w_ff}, cnt_ff);
                  ptr_in.j   = ptr_in.mid;
                  ptr_in.hi  = clamp({1'b0, ptr_ff.hi} + w_dbl, cnt_ff);
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_beat) begin
               if (at_final) begin
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  ptr_in.i = ptr_ff.i + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         w_ff     <= CNT_W'(1);
         src_ff   <= 1'b0;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         w_ff     <= w_in;
         src_ff   <= src_in;
         ptr_ff   <= ptr_in;
      end
   end

   // buffer writes: loading goes to the run buffer, merging to the buffer that is not the source of the pass
   always_comb begin
      elm_we  = 1'b0;
      scr_we  = 1'b0;
      wr_addr = ptr_ff.k[AW-1:0];
      wr_data = step_data;
      if (state_ff == ST_LOAD) begin
         elm_we  = req_beat && (cnt_ff < CAP);
         wr_addr = cnt_ff[AW-1:0];
         wr_data = req_tdata;
      end else if (state_ff == ST_MERGE) begin
         elm_we = src_ff;
         scr_we = !src_ff;
      end
   end

   // run buffer, two registered read ports at the next cursor
   always_ff @(posedge clock) begin
      if (elm_we) begin
         elm_mem_ff[wr_addr] <= wr_data;
      end
      elm_a_ff <= elm_mem_ff[ptr_in.i[AW-1:0]];
      elm_b_ff <= elm_mem_ff[ptr_in.j[AW-1:0]];
   end

   // scratch buffer, same arrangement
   always_ff @(posedge clock) begin
      if (scr_we) begin
         scr_mem_ff[wr_addr] <= wr_data;
      end
      scr_a_ff <= scr_mem_ff[ptr_in.i[AW-1:0]];
      scr_b_ff <= scr_mem_ff[ptr_in.j[AW-1:0]];
   end

   // ports
   assign req_tready = state_ff == ST_LOAD;
   assign rsp_tvalid = state_ff == ST_SHOW;
   assign rsp_tdata  = head_a;
   assign rsp_tlast  = at_final;
   assign rsp_tuser  = ovf_ff;

`ifndef ASSERT_OFF
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CAP)
      else $error("run count above capacity");

   a_merge_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MERGE |->
         ptr_ff.k < ptr_ff.hi && ptr_ff.i <= ptr_ff.mid && ptr_ff.j <= ptr_ff.hi
         && ptr_ff.hi <= cnt_ff)
      else $error("merge cursor out of its runs");

   a_merge_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MERGE |->
         ptr_ff.k == (ptr_ff.i + ptr_ff.j - ptr_ff.mid))
      else $error("merge output slot out of step with run heads");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && rsp_tlast |=> req_tready && cnt_ff == '0 && !ovf_ff)
      else $error("run state not cleared after final beat");

   a_sides: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while a result is shown");
`endif

endmodule

FILE: hdl/msort_step.sv
// One step of a two-run merge: signed compare of the run heads, selection
// of the smaller one and advance of the cursor. Depends on msort_pkg.
`timescale 1ns / 1ps

module msort_step (
   input  msort_pkg::ptr_type               ptr_cur,
   input  logic [msort_pkg::DATA_W-1:0]     head_a,
   input  logic [msort_pkg::DATA_W-1:0]     head_b,
   output msort_pkg::ptr_type               ptr_nxt,
   output msort_pkg::step_type              stat,
   output logic [msort_pkg::DATA_W-1:0]     wr_data
);

   logic a_ok;
   logic b_ok;
   logic b_less;

   // run heads still inside their runs
   assign a_ok   = ptr_cur.i < ptr_cur.mid;
   assign b_ok   = ptr_cur.j < ptr_cur.hi;
   assign b_less = $signed(head_b) < $signed(head_a);

   // ties take the left run, so the merge is stable
   always_comb begin
      stat.take_j   = b_ok && (!a_ok || b_less);
      stat.blk_done = (ptr_cur.k + 1'b1) == ptr_cur.hi;
      wr_data       = stat.take_j ? head_b : head_a;
      ptr_nxt       = ptr_cur;
      ptr_nxt.k     = ptr_cur.k + 1'b1;
      if (stat.take_j) begin
         ptr_nxt.j = ptr_cur.j + 1'b1;
      end else begin
         ptr_nxt.i = ptr_cur.i + 1'b1;
      end
   end

endmodule
